### rtl/slb_pkg.sv
// Shared codes, types and the set-1 key table of the scancode line buffer.
package slb_pkg;

  // Field widths of the item beats
  localparam int CmdW  = 2;
  localparam int CodeW = 8;
  localparam int PosW  = 6;
  localparam int CharW = 8;
  localparam int FillW = 7;

  // Commands carried by an input beat
  typedef enum logic [CmdW-1:0] {
    CMD_SCAN  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Set-1 codes with a meaning of their own
  localparam logic [CodeW-1:0] SC_BREAK_LIMIT = 8'h80;
  localparam logic [CodeW-1:0] SC_ENTER       = 8'h1C;
  localparam logic [CodeW-1:0] SC_CAPS        = 8'h3A;
  localparam logic [CodeW-1:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [CodeW-1:0] SC_TAB         = 8'h0F;

  // Characters handled by name
  localparam logic [CharW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CH_CASE    = 8'h20;

  // Map a make code to its character; unmapped codes give zero
  function automatic logic [CharW-1:0] keymap(input logic [CodeW-1:0] code);
    logic [CharW-1:0] ch;
    case (code)
      8'h02:   ch = 8'h31;  // 1
      8'h03:   ch = 8'h32;
      8'h04:   ch = 8'h33;
      8'h05:   ch = 8'h34;
      8'h06:   ch = 8'h35;
      8'h07:   ch = 8'h36;
      8'h08:   ch = 8'h37;
      8'h09:   ch = 8'h38;
      8'h0A:   ch = 8'h39;
      8'h0B:   ch = 8'h30;  // 0
      8'h0C:   ch = 8'h27;  // apostrophe
      8'h0D:   ch = 8'hBF;  // inverted question mark
      8'h10:   ch = 8'h71;  // q
      8'h11:   ch = 8'h77;
      8'h12:   ch = 8'h65;
      8'h13:   ch = 8'h72;
      8'h14:   ch = 8'h74;
      8'h15:   ch = 8'h79;
      8'h16:   ch = 8'h75;
      8'h17:   ch = 8'h69;
      8'h18:   ch = 8'h6F;
      8'h19:   ch = 8'h70;  // p
      8'h1A:   ch = 8'hB4;  // acute accent
      8'h1B:   ch = 8'h2B;  // +
      8'h1E:   ch = 8'h61;  // a
      8'h1F:   ch = 8'h73;
      8'h20:   ch = 8'h64;
      8'h21:   ch = 8'h66;
      8'h22:   ch = 8'h67;
      8'h23:   ch = 8'h68;
      8'h24:   ch = 8'h6A;
      8'h25:   ch = 8'h6B;
      8'h26:   ch = 8'h6C;  // l
      8'h27:   ch = 8'hF1;  // n with tilde
      8'h28:   ch = 8'h7B;  // {
      8'h29:   ch = 8'h7C;  // |
      8'h2B:   ch = 8'h7D;  // }
      8'h2C:   ch = 8'h7A;  // z
      8'h2D:   ch = 8'h78;
      8'h2E:   ch = 8'h63;
      8'h2F:   ch = 8'h76;
      8'h30:   ch = 8'h62;
      8'h31:   ch = 8'h6E;
      8'h32:   ch = 8'h6D;  // m
      8'h33:   ch = 8'h2C;  // ,
      8'h34:   ch = 8'h2E;  // .
      8'h35:   ch = 8'h2D;  // -
      8'h37:   ch = 8'h2A;  // *
      8'h39:   ch = 8'h20;  // space
      8'h47:   ch = 8'h37;  // keypad 7
      8'h49:   ch = 8'h39;
      8'h4A:   ch = 8'h2D;
      8'h4C:   ch = 8'h35;
      8'h4E:   ch = 8'h2B;
      8'h4F:   ch = 8'h31;
      8'h51:   ch = 8'h33;  // keypad 3
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

### rtl/slb_in_if.sv
// Input channel of the scancode line buffer: command beats.
interface slb_in_if;
  import slb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [CodeW-1:0] scan_code;
  logic [PosW-1:0]  read_position;

  modport source (output valid, output command, output scan_code, output read_position,
                  input ready);
  modport sink   (input valid, input command, input scan_code, input read_position,
                  output ready);
endinterface

### rtl/slb_out_if.sv
// Output channel of the scancode line buffer: result beats.
interface slb_out_if;
  import slb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] written_char;
  logic [FillW-1:0] fill_count;
  logic             active_buffer;
  logic [CharW-1:0] read_data;
  logic             switch_shell;

  modport source (output valid, output written_char, output fill_count,
                  output active_buffer, output read_data, output switch_shell,
                  input ready);
  modport sink   (input valid, input written_char, input fill_count,
                  input active_buffer, input read_data, input switch_shell,
                  output ready);
endinterface

### rtl/scancode_line_buffer.sv
// Set-1 scancode decoder that fills two switchable line buffers.
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------------------
//   in_i    | in  | command, scan_code, read_position
//   out_o   | out | written_char, fill_count, active_buffer, read_data, switch_shell
//
// One command beat is taken per cycle unless out_o stalls; the accepting edge loads
// its result beat into the output register and finishes the decode, count update and
// line store write; a read uses the registered read port of each line store.
// in_i.ready stays high while the output register is empty or being drained, so a
// stall on out_o holds off new beats for as long as the stall lasts. Reset clears
// counts, flags and the high-water mark of each line; bytes at or above the mark
// read as zero, so no clearing pass is needed.
module scancode_line_buffer #(
  parameter int LINE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  slb_in_if.sink    in_i,
  slb_out_if.source out_o
);
  import slb_pkg::*;

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int PW = ((AW > PosW) ? AW : PosW) + 1;

  // Line stores
  logic [CharW-1:0]      store_a [LINE_DEPTH];
  logic [CharW-1:0]      store_b [LINE_DEPTH];

  // Control state; every byte below a high-water mark was written since the last clear
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] hwm_a_q, hwm_a_d, hwm_b_q, hwm_b_d;
  logic          sel_q, sel_d, caps_q, caps_d;

  // Output register
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic [FillW-1:0] out_fill_q;
  logic             out_sel_q;
  logic             out_pulse_q, out_pulse_d;
  logic             rd_hit_q, rd_hit_d;
  logic             rd_sel_q;
  logic [CharW-1:0] rd_a_q, rd_b_q;

  // Step decode
  logic             accept;
  logic [CW-1:0]    cnt_act, cnt_nxt;
  logic [CW-1:0]    hwm_act, hwm_nxt;
  logic             full, store_req, we, clr;
  logic [CharW-1:0] store_ch, key_ch;
  logic [AW-1:0]    wr_idx, pos_idx;
  logic [PW-1:0]    pos_ext;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign cnt_act = sel_q ? cnt_b_q : cnt_a_q;
  assign hwm_act = sel_q ? hwm_b_q : hwm_a_q;
  assign full    = (cnt_act == CW'(LINE_DEPTH));
  assign wr_idx  = cnt_act[AW-1:0];
  assign pos_ext = PW'(in_i.read_position);
  assign pos_idx = pos_ext[AW-1:0];

  // Look up the key and apply caps lock to a..z
  always_comb begin
    key_ch = keymap(in_i.scan_code);
    if (caps_q && (key_ch >= CH_LOWER_A) && (key_ch <= CH_LOWER_Z)) begin
      key_ch = key_ch - CH_CASE;
    end
  end

  // Decode one command beat
  always_comb begin
    store_req   = 1'b0;
    store_ch    = '0;
    clr         = 1'b0;
    cnt_nxt     = cnt_act;
    caps_d      = caps_q;
    sel_d       = sel_q;
    out_pulse_d = 1'b0;
    rd_hit_d    = 1'b0;
    case (in_i.command)
      CMD_SCAN: begin
        if (in_i.scan_code > SC_BREAK_LIMIT) begin
          // break code: drop
        end else if (in_i.scan_code == SC_ENTER) begin
          store_req = 1'b1;
          store_ch  = CH_NEWLINE;
        end else if (in_i.scan_code == SC_CAPS) begin
          caps_d = !caps_q;
        end else if (in_i.scan_code == SC_BACKSPACE) begin
          if (cnt_act != '0) begin
            cnt_nxt = cnt_act - CW'(1);
          end
        end else if (in_i.scan_code == SC_TAB) begin
          sel_d       = !sel_q;
          out_pulse_d = 1'b1;
        end else begin
          store_req = 1'b1;
          store_ch  = key_ch;
        end
      end
      CMD_CLEAR: begin
        clr     = 1'b1;
        cnt_nxt = '0;
      end
      CMD_READ: begin
        rd_hit_d = (pos_ext < PW'(hwm_act));
      end
      default: begin
      end
    endcase
    we         = store_req && !full;
    out_char_d = we ? store_ch : '0;
    if (we) begin
      cnt_nxt = cnt_act + CW'(1);
    end
    // Raise the mark when writing at it; drop it on clear
    hwm_nxt = hwm_act;
    if (clr) begin
      hwm_nxt = '0;
    end else if (we && (cnt_act == hwm_act)) begin
      hwm_nxt = hwm_act + CW'(1);
    end
    cnt_a_d = sel_q ? cnt_a_q : cnt_nxt;
    cnt_b_d = sel_q ? cnt_nxt : cnt_b_q;
    hwm_a_d = sel_q ? hwm_a_q : hwm_nxt;
    hwm_b_d = sel_q ? hwm_nxt : hwm_b_q;
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      hwm_a_q     <= '0;
      hwm_b_q     <= '0;
      sel_q       <= 1'b0;
      caps_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_a_q     <= cnt_a_d;
        cnt_b_q     <= cnt_b_d;
        hwm_a_q     <= hwm_a_d;
        hwm_b_q     <= hwm_b_d;
        sel_q       <= sel_d;
        caps_q      <= caps_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write and read the line stores; load the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (we && !sel_q) begin
        store_a[wr_idx] <= store_ch;
      end
      if (we && sel_q) begin
        store_b[wr_idx] <= store_ch;
      end
      rd_a_q      <= store_a[pos_idx];
      rd_b_q      <= store_b[pos_idx];
      rd_sel_q    <= sel_q;
      rd_hit_q    <= rd_hit_d;
      out_char_q  <= out_char_d;
      out_fill_q  <= FillW'(sel_d ? cnt_b_d : cnt_a_d);
      out_sel_q   <= sel_d;
      out_pulse_q <= out_pulse_d;
    end
  end

  // Drive the result beat
  assign out_o.valid         = out_valid_q;
  assign out_o.written_char  = out_char_q;
  assign out_o.fill_count    = out_fill_q;
  assign out_o.active_buffer = out_sel_q;
  assign out_o.read_data     = rd_hit_q ? (rd_sel_q ? rd_b_q : rd_a_q) : '0;
  assign out_o.switch_shell  = out_pulse_q;

endmodule
